// File: design/video_memory_register_port_assert.svh
// Assertion macros used by the video memory register port RTL.
`ifndef VIDEO_MEMORY_REGISTER_PORT_ASSERT_SVH
`define VIDEO_MEMORY_REGISTER_PORT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define VMRP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define VMRP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/vmrp_pkg.sv
// Types, constants and address decode for the video memory register port.
`default_nettype none

package vmrp_pkg;

    localparam int VADDR_W   = 14;
    localparam int PATTERN_D = 8192;
    localparam int NAME_D    = 2048;
    localparam int PALETTE_D = 32;
    localparam int PATTERN_AW = $clog2(PATTERN_D);
    localparam int NAME_AW    = $clog2(NAME_D);
    localparam int PALETTE_AW = $clog2(PALETTE_D);

    localparam logic       CMD_WRITE = 1'b0;
    localparam logic       CMD_READ  = 1'b1;

    localparam logic [2:0] REG_CONTROL = 3'd0;
    localparam logic [2:0] REG_MASK    = 3'd1;
    localparam logic [2:0] REG_STATUS  = 3'd2;
    localparam logic [2:0] REG_ADDRESS = 3'd6;
    localparam logic [2:0] REG_DATA    = 3'd7;

    localparam logic [7:0] PAL_MASK_GRAY  = 8'h30;
    localparam logic [7:0] PAL_MASK_COLOR = 8'h3F;
    localparam logic [5:0] PAL_PAGE       = 6'h3F;

    typedef enum logic {
        S_IDLE,
        S_READ
    } state_t;

    typedef enum logic [1:0] {
        RGN_PATTERN,
        RGN_NAME,
        RGN_PALETTE
    } region_t;

    typedef struct packed {
        region_t                 region;
        logic [PATTERN_AW-1:0]   pat_idx;
        logic [NAME_AW-1:0]      name_idx;
        logic [PALETTE_AW-1:0]   pal_idx;
    } vaddr_dec_t;

    // mirror: 0 selects table by address bit 10, 1 by bit 11
    function automatic vaddr_dec_t vmrp_decode(input logic [VADDR_W-1:0] a,
                                               input logic mirror);
        vaddr_dec_t d;
        logic       tbl;
        logic [4:0] p;
        tbl = mirror ? a[11] : a[10];
        p   = a[4:0];
        // sprite backdrop entries fold onto the background ones
        if (p[4] && (p[1:0] == 2'b00))
        begin
            p[4] = 1'b0;
        end
        d.pat_idx  = a[PATTERN_AW-1:0];
        d.name_idx = {tbl, a[9:0]};
        d.pal_idx  = p;
        if (!a[13])
        begin
            d.region = RGN_PATTERN;
        end
        else if (a[13:8] == PAL_PAGE)
        begin
            d.region = RGN_PALETTE;
        end
        else
        begin
            d.region = RGN_NAME;
        end
        return d;
    endfunction

endpackage

`default_nettype wire

// File: design/vmrp_ram.sv
// Generic single-port RAM with registered read data.
`default_nettype none

module vmrp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic                     we,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: design/video_memory_register_port.sv
// Timing: register, status and write words give their response word in the cycle after accept.
// A data read passes the synchronous memory read register, then is picked and buffered in S_READ.
// Throughput: one word per cycle while the response is not stalled; a data read holds the port in S_READ.
// A stalled response word in the output register holds off the next command word.
// Reset (rst_n, async, active low) clears all registers but the response data; the memories are not cleared,
// there is no clearing pass and the port is ready right after reset.
`default_nettype none
`include "video_memory_register_port_assert.svh"

module video_memory_register_port (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_we,
    input  wire logic       cfg_wdata,
    input  wire logic       cmd_valid,
    output logic            cmd_stall,
    input  wire logic       command,
    input  wire logic [2:0] reg_index,
    input  wire logic [7:0] write_data,
    output logic            rsp_valid,
    input  wire logic       rsp_stall,
    output logic      [7:0] read_data
);
    import vmrp_pkg::*;

    state_t               state_reg, state_next;
    logic                 mirror_reg;
    logic                 gray_reg, gray_next;
    logic                 high_next_reg, high_next_next;
    logic [VADDR_W-1:0]   vaddr_reg, vaddr_next;
    logic [7:0]           rbuf_reg, rbuf_next;
    logic                 rsp_valid_reg, rsp_valid_next;
    logic [7:0]           rsp_data_reg, rsp_data_next;

    logic                 cmd_accept;
    logic                 data_rd;
    logic                 data_wr;
    logic                 rsp_free;
    vaddr_dec_t           dec;
    logic [7:0]           pat_rdata, name_rdata, pal_rdata;
    logic [7:0]           fetched;
    logic [7:0]           imm_data;

    assign cmd_accept = cmd_valid && !cmd_stall;
    assign data_rd    = cmd_accept && (command == CMD_READ) && (reg_index == REG_DATA);
    assign data_wr    = cmd_accept && (command == CMD_WRITE) && (reg_index == REG_DATA);
    assign rsp_free   = !rsp_valid_reg || !rsp_stall;
    assign dec        = vmrp_decode(vaddr_reg, mirror_reg);

    vmrp_ram #(.WIDTH(8), .DEPTH(PATTERN_D)) u_pattern (
        .clk   (clk),
        .addr  (dec.pat_idx),
        .we    (data_wr && (dec.region == RGN_PATTERN)),
        .wdata (write_data),
        .rdata (pat_rdata)
    );

    vmrp_ram #(.WIDTH(8), .DEPTH(NAME_D)) u_name (
        .clk   (clk),
        .addr  (dec.name_idx),
        .we    (data_wr && (dec.region == RGN_NAME)),
        .wdata (write_data),
        .rdata (name_rdata)
    );

    vmrp_ram #(.WIDTH(8), .DEPTH(PALETTE_D)) u_palette (
        .clk   (clk),
        .addr  (dec.pal_idx),
        .we    (data_wr && (dec.region == RGN_PALETTE)),
        .wdata (write_data),
        .rdata (pal_rdata)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (data_rd)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        case (state_reg)
            S_IDLE:  cmd_stall = !rsp_free;
            S_READ:  cmd_stall = 1'b1;
            default: cmd_stall = 1'b1;
        endcase
    end

    // palette reads come back masked and bypass the buffer delay
    always_comb
    begin
        case (dec.region)
            RGN_PATTERN: fetched = pat_rdata;
            RGN_NAME:    fetched = name_rdata;
            RGN_PALETTE: fetched = pal_rdata & (gray_reg ? PAL_MASK_GRAY : PAL_MASK_COLOR);
            default:     fetched = pat_rdata;
        endcase
    end

    // status read: vblank is set by the read itself, so bit 7 always reads one
    always_comb
    begin
        imm_data = 8'h00;
        if ((command == CMD_READ) && (reg_index == REG_STATUS))
        begin
            imm_data = {1'b1, 2'b00, rbuf_reg[4:0]};
        end
    end

    // register updates; control and status writes have no visible effect here
    always_comb
    begin
        gray_next      = gray_reg;
        high_next_next = high_next_reg;
        vaddr_next     = vaddr_reg;
        rbuf_next      = rbuf_reg;
        if (cmd_accept && (command == CMD_WRITE))
        begin
            if (reg_index == REG_MASK)
            begin
                gray_next = write_data[0];
            end
            else if (reg_index == REG_ADDRESS)
            begin
                if (!high_next_reg)
                begin
                    vaddr_next[VADDR_W-1:8] = write_data[VADDR_W-9:0];
                end
                else
                begin
                    vaddr_next[7:0] = write_data;
                end
                high_next_next = !high_next_reg;
            end
        end
        else if (cmd_accept && (reg_index == REG_STATUS))
        begin
            high_next_next = 1'b0;
        end
        if (state_reg == S_READ)
        begin
            rbuf_next = fetched;
        end
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_data_next  = rsp_data_reg;
        if (cmd_accept && !data_rd)
        begin
            rsp_valid_next = 1'b1;
            rsp_data_next  = imm_data;
        end
        else if (state_reg == S_READ)
        begin
            rsp_valid_next = 1'b1;
            rsp_data_next  = (dec.region == RGN_PALETTE) ? fetched : rbuf_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mirror_reg    <= 1'b0;
            gray_reg      <= 1'b0;
            high_next_reg <= 1'b0;
            vaddr_reg     <= '0;
            rbuf_reg      <= 8'h00;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            if (cfg_we)
            begin
                mirror_reg <= cfg_wdata;
            end
            gray_reg      <= gray_next;
            high_next_reg <= high_next_next;
            vaddr_reg     <= vaddr_next;
            rbuf_reg      <= rbuf_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_data_reg <= rsp_data_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign read_data = rsp_data_reg;

    `VMRP_ASSERT_NEXT(a_rd_enters_read, data_rd,
        (state_reg == S_READ) && !rsp_valid_reg, "data read did not start a memory fetch")
    `VMRP_ASSERT_NEXT(a_read_responds, state_reg == S_READ,
        rsp_valid_reg && (state_reg == S_IDLE), "memory fetch gave no response word")
    `VMRP_ASSERT_NEXT(a_imm_responds, cmd_accept && !data_rd,
        rsp_valid_reg && (state_reg == S_IDLE), "command word gave no response word")
    `VMRP_ASSERT_NEXT(a_status_clears,
        cmd_accept && (command == CMD_READ) && (reg_index == REG_STATUS),
        !high_next_reg, "status read left byte latch set")
    `VMRP_ASSERT_NOW(a_no_ram_write_busy, state_reg == S_READ, !data_wr,
        "memory write during fetch")

endmodule

`default_nettype wire

// File: dv/tb.sv
// Self-checking testbench for the video memory register port: directed and random CPU register traffic.
`timescale 1ns / 100ps

module tb;
    import vmrp_pkg::*;

    localparam int LIMIT_CYCLES   = 500000;
    localparam int PHASE_WORDS    = 533;
    localparam int NAME_KEY0      = PATTERN_D;
    localparam int PAL_KEY0       = PATTERN_D + NAME_D;
    localparam int STORE_KEYS     = PATTERN_D + NAME_D + PALETTE_D;
    localparam logic [2:0] REG_SPARE_FIRST = 3'd3;
    localparam logic [2:0] REG_SPARE_LAST  = 3'd5;

    typedef struct packed {
        logic       cmd;
        logic [2:0] sel;
        logic [7:0] wdata;
    } bus_word_t;

    logic       clk;
    logic       rst_n      = 1'b0;
    logic       cfg_we     = 1'b0;
    logic       cfg_wdata  = 1'b0;
    logic       cmd_valid  = 1'b0;
    logic       command    = 1'b0;
    logic [2:0] reg_index  = 3'd0;
    logic [7:0] write_data = 8'h00;
    logic       rsp_stall  = 1'b0;
    wire        cmd_stall;
    wire        rsp_valid;
    wire  [7:0] read_data;

    video_memory_register_port DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .cmd_valid  (cmd_valid),
        .cmd_stall  (cmd_stall),
        .command    (command),
        .reg_index  (reg_index),
        .write_data (write_data),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .read_data  (read_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // flat index over pattern, nametable and palette storage
    function automatic int store_key(input logic [15:0] addr, input logic mirror);
        logic       tbl;
        logic [4:0] pal;
        if (!addr[13])
        begin
            return int'(addr[12:0]);
        end
        if (addr[13:8] != PAL_PAGE)
        begin
            tbl = mirror ? addr[11] : addr[10];
            return NAME_KEY0 + int'({tbl, addr[9:0]});
        end
        pal = addr[4:0];
        if (pal[4] && pal[1:0] == 2'b00)
        begin
            pal[4] = 1'b0;
        end
        return PAL_KEY0 + int'(pal);
    endfunction

    // ---------------- port behavior predictor ----------------
    logic        mirror_now    = 1'b0;
    logic [7:0]  ctrl_shadow   = 8'h00;
    logic [7:0]  mask_shadow   = 8'h00;
    logic        vblank_shadow = 1'b0;
    logic        low_byte_next = 1'b0;
    logic [15:0] vaddr_shadow  = 16'h0000;
    logic [7:0]  rbuf_shadow   = 8'h00;
    logic [7:0]  vram_shadow [STORE_KEYS];
    logic [7:0]  exp_read_data [$];

    task automatic cpu_access(input bus_word_t w, output logic [7:0] rd);
        int         k;
        logic [7:0] fresh;
        rd = 8'h00;
        k  = store_key(vaddr_shadow, mirror_now);
        if (w.cmd == CMD_WRITE)
        begin
            case (w.sel)
                REG_CONTROL: ctrl_shadow = w.wdata;
                REG_MASK:    mask_shadow = w.wdata;
                REG_ADDRESS:
                begin
                    if (low_byte_next)
                    begin
                        vaddr_shadow[7:0] = w.wdata;
                    end
                    else
                    begin
                        vaddr_shadow[15:8] = w.wdata;
                    end
                    low_byte_next = !low_byte_next;
                end
                REG_DATA:    vram_shadow[k] = w.wdata;
                default:     ;
            endcase
        end
        else if (w.sel == REG_STATUS)
        begin
            vblank_shadow = 1'b1;
            rd            = {vblank_shadow, 2'b00, rbuf_shadow[4:0]};
            low_byte_next = 1'b0;
        end
        else if (w.sel == REG_DATA)
        begin
            fresh = vram_shadow[k];
            rd    = rbuf_shadow;
            // palette reads bypass the buffer
            if (k >= PAL_KEY0)
            begin
                fresh = fresh & (mask_shadow[0] ? PAL_MASK_GRAY : PAL_MASK_COLOR);
                rd    = fresh;
            end
            rbuf_shadow = fresh;
        end
    endtask

    // ---------------- stimulus planning ----------------
    bus_word_t   pending_words [$];
    logic [15:0] plan_addr     = 16'h0000;
    logic        plan_low_next = 1'b0;
    logic        plan_mirror   = 1'b0;
    bit          store_written [STORE_KEYS];
    logic [15:0] recent_addrs [$];
    int          words_planned = 0;
    int          send_gap_pct  = 0;
    int          rsp_stall_pct = 0;

    // queues one word; a data read of a never-written entry gets a fill write first
    task automatic add_word(input logic cmd, input logic [2:0] sel, input logic [7:0] wdata);
        int k;
        k = store_key(plan_addr, plan_mirror);
        if (cmd == CMD_READ && sel == REG_DATA && !store_written[k])
        begin
            pending_words.push_back('{CMD_WRITE, REG_DATA, 8'($urandom)});
            store_written[k] = 1'b1;
            words_planned++;
        end
        pending_words.push_back('{cmd, sel, wdata});
        if (cmd == CMD_WRITE && sel == REG_ADDRESS)
        begin
            if (plan_low_next)
            begin
                plan_addr[7:0] = wdata;
            end
            else
            begin
                plan_addr[15:8] = wdata;
            end
            plan_low_next = !plan_low_next;
        end
        else if (cmd == CMD_WRITE && sel == REG_DATA)
        begin
            store_written[k] = 1'b1;
        end
        else if (cmd == CMD_READ && sel == REG_STATUS)
        begin
            plan_low_next = 1'b0;
        end
        if (sel == REG_DATA || (cmd == CMD_READ && sel == REG_STATUS) ||
            (cmd == CMD_WRITE && (sel == REG_CONTROL || sel == REG_MASK ||
                                  sel == REG_ADDRESS)))
        begin
            words_planned++;
        end
    endtask

    task automatic random_traffic(input int n);
        int          stop_at;
        int          pick;
        logic [15:0] a;
        stop_at = words_planned + n;
        while (words_planned < stop_at)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
            begin
                // address pair then a few data accesses
                if (recent_addrs.size() != 0 && $urandom_range(0, 1) == 1)
                begin
                    a = recent_addrs[$urandom_range(0, recent_addrs.size() - 1)];
                    if ($urandom_range(0, 1) == 1)
                    begin
                        a = a ^ (16'h0001 << $urandom_range(4, 15));
                    end
                end
                else
                begin
                    a = 16'($urandom);
                    case ($urandom_range(0, 3))
                        0:       a[13:8] = 6'($urandom_range(0, 'h1F));
                        1:       a[13:8] = 6'($urandom_range('h20, 'h3E));
                        2:       a[13:8] = PAL_PAGE;
                        default: ;
                    endcase
                    if ($urandom_range(0, 3) != 0)
                    begin
                        a[15:14] = 2'b00;
                    end
                end
                recent_addrs.push_back(a);
                if (recent_addrs.size() > 16)
                begin
                    void'(recent_addrs.pop_front());
                end
                add_word(CMD_WRITE, REG_ADDRESS, a[15:8]);
                // occasionally break the pair with a latch reset
                if ($urandom_range(0, 19) == 0)
                begin
                    add_word(CMD_READ, REG_STATUS, 8'($urandom));
                end
                add_word(CMD_WRITE, REG_ADDRESS, a[7:0]);
                repeat ($urandom_range(1, 4))
                    add_word(1'($urandom_range(0, 1)), REG_DATA, 8'($urandom));
            end
            else if (pick < 65)
            begin
                repeat ($urandom_range(1, 3))
                    add_word(1'($urandom_range(0, 1)), REG_DATA, 8'($urandom));
            end
            else if (pick < 75)
            begin
                add_word(CMD_WRITE, REG_MASK, 8'($urandom));
            end
            else if (pick < 80)
            begin
                add_word(CMD_WRITE, REG_CONTROL, 8'($urandom));
            end
            else if (pick < 88)
            begin
                add_word(CMD_READ, REG_STATUS, 8'($urandom));
            end
            else
            begin
                add_word(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)), 8'($urandom));
            end
        end
    endtask

    // ---------------- driver ----------------
    logic word_taken = 1'b0;

    always @(negedge clk)
    begin : driver
        bus_word_t w;
        if (rst_n)
        begin
            if (!cmd_valid || word_taken)
            begin
                if (pending_words.size() != 0 && $urandom_range(0, 99) >= send_gap_pct)
                begin
                    w = pending_words.pop_front();
                    cmd_valid  <= 1'b1;
                    command    <= w.cmd;
                    reg_index  <= w.sel;
                    write_data <= w.wdata;
                end
                else
                begin
                    cmd_valid <= 1'b0;
                end
            end
            rsp_stall <= ($urandom_range(0, 99) < rsp_stall_pct);
        end
    end

    // ---------------- monitor ----------------
    int errors         = 0;
    int words_accepted = 0;
    int words_checked  = 0;

    always @(posedge clk)
    begin : monitor
        logic [7:0] want;
        word_taken <= rst_n && cmd_valid && !cmd_stall;
        if (rst_n)
        begin
            if (cfg_we)
            begin
                mirror_now = cfg_wdata;
            end
            if (cmd_valid && !cmd_stall)
            begin
                cpu_access('{command, reg_index, write_data}, want);
                exp_read_data.push_back(want);
                words_accepted++;
            end
            if (rsp_valid && !rsp_stall)
            begin
                if (exp_read_data.size() == 0)
                begin
                    $display("%0t: unexpected response, expected none, actual 0x%02h",
                             $time, read_data);
                    errors++;
                end
                else
                begin
                    want = exp_read_data.pop_front();
                    words_checked++;
                    if (read_data !== want)
                    begin
                        $display("%0t: read_data mismatch, expected 0x%02h, actual 0x%02h",
                                 $time, want, read_data);
                        errors++;
                    end
                end
            end
        end
    end

    int cycle_count = 0;

    always @(posedge clk)
    begin : watchdog
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("tb: done, errors");
            $finish;
        end
    end

    // ---------------- sequencing ----------------
    task automatic wait_drained();
        while (pending_words.size() != 0 || cmd_valid || exp_read_data.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_phase(input logic mirror, input int gap_pct, input int stall_pct);
        wait_drained();
        repeat (4) @(posedge clk);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= mirror;
        @(negedge clk);
        cfg_we        <= 1'b0;
        plan_mirror   = mirror;
        send_gap_pct  = gap_pct;
        rsp_stall_pct = stall_pct;
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        set_phase(1'b0, 28, 66);
        add_word(CMD_WRITE, REG_CONTROL, 8'hFF);
        add_word(CMD_WRITE, REG_MASK, 8'h00);
        add_word(CMD_READ, REG_STATUS, 8'h00);
        add_word(CMD_WRITE, REG_ADDRESS, 8'h00);
        add_word(CMD_WRITE, REG_ADDRESS, 8'h00);
        add_word(CMD_WRITE, REG_DATA, 8'hFF);
        add_word(CMD_READ, REG_DATA, 8'h00);
        add_word(CMD_READ, REG_DATA, 8'hFF);
        add_word(CMD_READ, REG_STATUS, 8'hFF);
        // status read between the address bytes restarts the pair
        add_word(CMD_WRITE, REG_ADDRESS, 8'hFF);
        add_word(CMD_READ, REG_STATUS, 8'h00);
        add_word(CMD_WRITE, REG_ADDRESS, 8'h3F);
        add_word(CMD_WRITE, REG_ADDRESS, 8'h10);
        add_word(CMD_WRITE, REG_DATA, 8'hAB);
        // top address bits ignored; sprite backdrop entry folds to 0x3F00
        add_word(CMD_WRITE, REG_ADDRESS, 8'hFF);
        add_word(CMD_WRITE, REG_ADDRESS, 8'h00);
        add_word(CMD_READ, REG_DATA, 8'h00);
        add_word(CMD_WRITE, REG_MASK, 8'h01);
        add_word(CMD_READ, REG_DATA, 8'h00);
        add_word(CMD_WRITE, REG_ADDRESS, 8'h24);
        add_word(CMD_WRITE, REG_ADDRESS, 8'h00);
        add_word(CMD_WRITE, REG_DATA, 8'h5A);
        add_word(CMD_WRITE, REG_ADDRESS, 8'h2C);
        add_word(CMD_WRITE, REG_ADDRESS, 8'h00);
        add_word(CMD_READ, REG_DATA, 8'h00);
        add_word(CMD_READ, REG_DATA, 8'h00);
        add_word(CMD_WRITE, REG_STATUS, 8'hFF);
        add_word(CMD_WRITE, REG_SPARE_LAST, 8'hFF);
        add_word(CMD_READ, REG_SPARE_FIRST, 8'h00);
        add_word(CMD_READ, REG_CONTROL, 8'h00);
        add_word(CMD_READ, REG_ADDRESS, 8'h00);

        set_phase(1'b1, 28, 66);
        random_traffic(PHASE_WORDS);
        set_phase(1'b0, 66, 28);
        random_traffic(PHASE_WORDS);
        set_phase(1'b1, 0, 0);
        random_traffic(PHASE_WORDS);

        wait_drained();
        repeat (10) @(posedge clk);
        $display("tb: %0d words accepted, %0d responses checked", words_accepted, words_checked);
        $display("tb: both mirror modes, gap/stall profiles 28/66, 66/28 and none");
        if (errors == 0)
        begin
            $display("tb: done, clean");
        end
        else
        begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule

// File: video_memory_register_port.f
+incdir+design
design/vmrp_pkg.sv
design/vmrp_ram.sv
design/video_memory_register_port.sv
dv/tb.sv
